[rtl/sawarq_pkg.sv]
package sawarq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int CHUNK_BYTES_DEF = 496;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 32;
    localparam int SEQ_W    = 16;
    localparam int LEN_W    = 16;
    localparam int TICK_W   = 32;
    localparam int SIZE_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TICK_W-1:0] RETRY_RESET      = 32'd500;
    localparam logic              TIMEOUT_EN_RESET = 1'b1;
    localparam logic [SIZE_W-1:0] COUNT_PKT_SIZE   = 11'd4;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_RECV = 2'd0,
        OP_POLL = 2'd1,
        OP_ENQ  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETRY_TIMEOUT = 1'd0,
        CFG_TIMEOUT_EN    = 1'd1
    } t_cfg_idx;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

[rtl/sawarq_len_queue.sv]
module sawarq_len_queue import sawarq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_ctrl          i_ctrl,
    input  logic [LEN_W-1:0] i_push_len,
    output t_q_stat          o_stat,
    output logic [LEN_W-1:0] o_head_len
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [LEN_W-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW:0]      tail_sum;
    logic [AW-1:0]    wr_addr;
    logic [LEN_W-1:0] r_head_len;

    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign wr_addr  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // read the next head every cycle; forward a write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[wr_addr] <= i_push_len;
        end
        if (i_ctrl.push && wr_addr == n_head) begin
            r_head_len <= i_push_len;
        end else begin
            r_head_len <= r_mem[n_head];
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_head_len   = r_head_len;

endmodule

[rtl/stop_and_wait_fragment_arq.sv]
// Channel   Handshake                 Payload
// in        i_in_valid / o_in_ready   i_operation .. i_now_tick
// out       o_out_valid / i_out_ready o_out_kind .. o_payload_size
// cfg       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the skid stage is empty; its result is registered in the output stage.
// Queue head length comes from a registered memory read of the next head, with write forwarding.
// Synchronous reset clears control state, not queue memory or output data; no clearing pass is needed.
// A stalled output parks one result in a skid stage; input stalls only while it is full.
module stop_and_wait_fragment_arq import sawarq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_operation,
    input  logic                  i_is_ack,
    input  logic [IDX_W-1:0]      i_pkt_index,
    input  logic [SEQ_W-1:0]      i_pkt_seq,
    input  logic [SEQ_W-1:0]      i_pkt_count_word,
    input  logic [LEN_W-1:0]      i_message_length,
    input  logic [TICK_W-1:0]     i_now_tick,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_kind,
    output logic [IDX_W-1:0]      o_out_index,
    output logic [SEQ_W-1:0]      o_out_seq,
    output logic [SEQ_W-1:0]      o_fragment_total,
    output logic [LEN_W-1:0]      o_payload_offset,
    output logic [SIZE_W-1:0]     o_payload_size,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W     = LEN_W + 1;
    localparam int CHUNK_LOG = $clog2(CHUNK_BYTES);
    localparam int DIV_SHIFT = SUM_W + CHUNK_LOG;
    localparam int DIV_MULT  = ((2 ** DIV_SHIFT) + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int PROD_W    = DIV_SHIFT + SUM_W;
    localparam int OFF_W     = SEQ_W + CHUNK_LOG + 1;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  index;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  total;
        logic [LEN_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } t_result;

    logic              accept;
    t_op               op;
    t_q_ctrl           q_ctrl;
    t_q_stat           q_stat;
    logic [LEN_W-1:0]  head_len;

    logic [TICK_W-1:0] r_retry;
    logic              r_timeout_en;
    logic              r_awaiting;
    logic              n_awaiting;
    logic [IDX_W-1:0]  r_send_index;
    logic [IDX_W-1:0]  n_send_index;
    logic [SEQ_W-1:0]  r_send_seq;
    logic [SEQ_W-1:0]  n_send_seq;
    logic [SEQ_W-1:0]  r_send_total;
    logic [SEQ_W-1:0]  n_send_total;
    logic [OFF_W-1:0]  r_send_off;
    logic [OFF_W-1:0]  n_send_off;
    logic [TICK_W-1:0] r_sent_tick;
    logic [TICK_W-1:0] n_sent_tick;
    logic [IDX_W-1:0]  r_recv_index;
    logic [IDX_W-1:0]  n_recv_index;
    logic [SEQ_W-1:0]  r_recv_seq;
    logic [SEQ_W-1:0]  n_recv_seq;
    logic [SEQ_W-1:0]  r_recv_total;
    logic [SEQ_W-1:0]  n_recv_total;

    logic [SUM_W-1:0]  len_sum;
    logic [PROD_W-1:0] div_prod;
    logic [SEQ_W-1:0]  div_total;
    logic              off_in_msg;
    logic [LEN_W-1:0]  frag_rem;
    logic [SIZE_W-1:0] frag_size;
    logic [SEQ_W-1:0]  recv_total_eff;

    logic              res_valid;
    t_result           res;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;
    logic              out_free;

    sawarq_len_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (q_ctrl),
        .i_push_len (i_message_length),
        .o_stat     (q_stat),
        .o_head_len (head_len)
    );

    assign accept = i_in_valid && o_in_ready;
    assign op     = t_op'(i_operation);

    // ceil(len / chunk) by reciprocal multiply
    assign len_sum   = SUM_W'(head_len) + SUM_W'(CHUNK_BYTES - 1);
    assign div_prod  = PROD_W'(len_sum) * PROD_W'(DIV_MULT);
    assign div_total = div_prod[DIV_SHIFT +: SEQ_W];

    assign off_in_msg = (r_send_off < OFF_W'(head_len));
    assign frag_rem   = head_len - r_send_off[LEN_W-1:0];
    assign frag_size  = !off_in_msg ? '0 :
                        (frag_rem > LEN_W'(CHUNK_BYTES)) ? SIZE_W'(CHUNK_BYTES) :
                        SIZE_W'(frag_rem);

    assign recv_total_eff = (r_recv_seq == '0) ? i_pkt_count_word : r_recv_total;

    always_comb begin
        n_awaiting   = r_awaiting;
        n_send_index = r_send_index;
        n_send_seq   = r_send_seq;
        n_send_total = r_send_total;
        n_send_off   = r_send_off;
        n_sent_tick  = r_sent_tick;
        n_recv_index = r_recv_index;
        n_recv_seq   = r_recv_seq;
        n_recv_total = r_recv_total;
        q_ctrl       = '0;
        res_valid    = 1'b0;
        res          = '0;
        if (accept) begin
            unique case (op)
                OP_RECV: begin
                    if (i_is_ack) begin
                        if (!q_stat.empty && r_awaiting && r_send_index == i_pkt_index &&
                            r_send_seq == i_pkt_seq) begin
                            n_awaiting = 1'b0;
                            if (r_send_seq == r_send_total) begin
                                n_send_seq   = '0;
                                n_send_index = r_send_index + 1'b1;
                                n_send_off   = '0;
                                q_ctrl.pop   = 1'b1;
                            end else begin
                                n_send_seq = r_send_seq + 1'b1;
                                n_send_off = (r_send_seq == '0) ? '0 :
                                             r_send_off + OFF_W'(CHUNK_BYTES);
                            end
                        end
                    end else if (r_recv_index == i_pkt_index && r_recv_seq == i_pkt_seq) begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_ACK;
                        res.index    = r_recv_index;
                        res.seq      = r_recv_seq;
                        n_recv_total = recv_total_eff;
                        if (r_recv_seq == recv_total_eff) begin
                            n_recv_seq   = '0;
                            n_recv_index = r_recv_index + 1'b1;
                        end else begin
                            n_recv_seq = r_recv_seq + 1'b1;
                        end
                    end
                end
                OP_POLL: begin
                    if (!q_stat.empty) begin
                        if (!r_awaiting) begin
                            res_valid = 1'b1;
                            res.kind  = KIND_DATA;
                            res.index = r_send_index;
                            if (r_send_seq == '0) begin
                                n_send_total = div_total;
                                res.total    = div_total;
                                res.size     = COUNT_PKT_SIZE;
                            end else begin
                                res.seq    = r_send_seq;
                                res.offset = r_send_off[LEN_W-1:0];
                                res.size   = frag_size;
                            end
                            n_awaiting = 1'b1;
                            if (r_timeout_en) begin
                                n_sent_tick = i_now_tick;
                            end
                        end else if (r_timeout_en &&
                                     (i_now_tick - r_sent_tick) >= r_retry) begin
                            n_awaiting = 1'b0;
                        end
                    end
                end
                OP_ENQ: begin
                    if (!q_stat.full) begin
                        q_ctrl.push = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry      <= RETRY_RESET;
            r_timeout_en <= TIMEOUT_EN_RESET;
            r_awaiting   <= 1'b0;
            r_send_index <= '0;
            r_send_seq   <= '0;
            r_send_total <= '0;
            r_send_off   <= '0;
            r_sent_tick  <= '0;
            r_recv_index <= '0;
            r_recv_seq   <= '0;
            r_recv_total <= '0;
        end else begin
            r_awaiting   <= n_awaiting;
            r_send_index <= n_send_index;
            r_send_seq   <= n_send_seq;
            r_send_total <= n_send_total;
            r_send_off   <= n_send_off;
            r_sent_tick  <= n_sent_tick;
            r_recv_index <= n_recv_index;
            r_recv_seq   <= n_recv_seq;
            r_recv_total <= n_recv_total;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RETRY_TIMEOUT: r_retry      <= i_cfg_data[TICK_W-1:0];
                    CFG_TIMEOUT_EN:    r_timeout_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register with one skid entry
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= res_valid || r_skid_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_in_ready       = !r_skid_valid;
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out.kind;
    assign o_out_index      = r_out.index;
    assign o_out_seq        = r_out.seq;
    assign o_fragment_total = r_out.total;
    assign o_payload_offset = r_out.offset;
    assign o_payload_size   = r_out.size;

endmodule

[rtl/sawarq_checker.sv]
module sawarq_checker import sawarq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_out_kind,
    input logic [IDX_W-1:0]  o_out_index,
    input logic [SEQ_W-1:0]  o_out_seq,
    input logic [SEQ_W-1:0]  o_fragment_total,
    input logic [LEN_W-1:0]  o_payload_offset,
    input logic [SIZE_W-1:0] o_payload_size
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_kind) &&
        $stable(o_out_index) && $stable(o_out_seq) && $stable(o_payload_size))
        else $error("output transfer changed while stalled");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_ACK |->
        o_payload_size == '0 && o_fragment_total == '0 && o_payload_offset == '0)
        else $error("acknowledgement carries payload fields");

    a_count_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_DATA && o_out_seq == '0 |->
        o_payload_size == COUNT_PKT_SIZE && o_payload_offset == '0)
        else $error("count packet with wrong size or offset");

endmodule

bind stop_and_wait_fragment_arq sawarq_checker u_sawarq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_kind       (o_out_kind),
    .o_out_index      (o_out_index),
    .o_out_seq        (o_out_seq),
    .o_fragment_total (o_fragment_total),
    .o_payload_offset (o_payload_offset),
    .o_payload_size   (o_payload_size)
);

[test/stop_and_wait_fragment_arq_test.sv]
`timescale 1ns / 100ps

module stop_and_wait_fragment_arq_test;
    import sawarq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_EVENTS = 80;

    typedef struct packed {
        t_op               op;
        logic              is_ack;
        logic [IDX_W-1:0]  pkt_index;
        logic [SEQ_W-1:0]  pkt_seq;
        logic [SEQ_W-1:0]  pkt_count_word;
        logic [LEN_W-1:0]  message_length;
        logic [TICK_W-1:0] now_tick;
    } arq_event_t;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  index;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  total;
        logic [LEN_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } arq_packet_t;

    typedef struct packed {
        logic [QUEUE_DEPTH_DEF-1:0][LEN_W-1:0] lengths;
        logic [7:0]        head;
        logic [7:0]        count;
        logic              awaiting;
        logic [IDX_W-1:0]  send_index;
        logic [SEQ_W-1:0]  send_seq;
        logic [SEQ_W-1:0]  send_total;
        logic [TICK_W-1:0] sent_at;
        logic [IDX_W-1:0]  recv_index;
        logic [SEQ_W-1:0]  recv_seq;
        logic [SEQ_W-1:0]  recv_total;
        logic [TICK_W-1:0] retry;
        logic              timeout_en;
    } arq_state_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = OP_RECV;
    logic                  i_is_ack = 1'b0;
    logic [IDX_W-1:0]      i_pkt_index = '0;
    logic [SEQ_W-1:0]      i_pkt_seq = '0;
    logic [SEQ_W-1:0]      i_pkt_count_word = '0;
    logic [LEN_W-1:0]      i_message_length = '0;
    logic [TICK_W-1:0]     i_now_tick = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_out_kind;
    logic [IDX_W-1:0]      o_out_index;
    logic [SEQ_W-1:0]      o_out_seq;
    logic [SEQ_W-1:0]      o_fragment_total;
    logic [LEN_W-1:0]      o_payload_offset;
    logic [SIZE_W-1:0]     o_payload_size;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_RETRY_TIMEOUT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    arq_state_t        link_state;
    arq_state_t        plan_state;
    arq_event_t        stim_events[$];
    arq_packet_t       due_packets[$];
    logic [TICK_W-1:0] tick_now = '0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                error_count = 0;
    int                quiet_cycles = 0;
    int                issued_count = 0;
    int                accepted_count = 0;

    stop_and_wait_fragment_arq dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_is_ack         (i_is_ack),
        .i_pkt_index      (i_pkt_index),
        .i_pkt_seq        (i_pkt_seq),
        .i_pkt_count_word (i_pkt_count_word),
        .i_message_length (i_message_length),
        .i_now_tick       (i_now_tick),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_kind       (o_out_kind),
        .o_out_index      (o_out_index),
        .o_out_seq        (o_out_seq),
        .o_fragment_total (o_fragment_total),
        .o_payload_offset (o_payload_offset),
        .o_payload_size   (o_payload_size),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the link by one event; return 1 with the packet it sends, if any.
    function automatic bit arq_advance(inout arq_state_t s, input arq_event_t ev,
                                       output arq_packet_t pkt);
        logic [31:0] len;
        logic [31:0] nxt;
        logic [31:0] rem;
        logic [31:0] elapsed;
        logic [63:0] off;
        pkt = '0;
        case (ev.op)
            OP_RECV: begin
                if (ev.is_ack) begin
                    if (s.count != 0 && s.awaiting && s.send_index == ev.pkt_index &&
                        s.send_seq == ev.pkt_seq) begin
                        nxt = {16'd0, s.send_seq} + 32'd1;
                        s.awaiting = 1'b0;
                        if (nxt == {16'd0, s.send_total} + 32'd1) begin
                            s.send_seq = '0;
                            s.send_index = s.send_index + 1;
                            s.head = (s.head + 1) % QUEUE_DEPTH_DEF;
                            s.count = s.count - 1;
                        end else begin
                            s.send_seq = nxt[15:0];
                        end
                    end
                    return 1'b0;
                end
                if (s.recv_index == ev.pkt_index && s.recv_seq == ev.pkt_seq) begin
                    pkt.kind = KIND_ACK;
                    pkt.index = s.recv_index;
                    pkt.seq = s.recv_seq;
                    if (s.recv_seq == 0)
                        s.recv_total = ev.pkt_count_word;
                    nxt = {16'd0, s.recv_seq} + 32'd1;
                    if (nxt == {16'd0, s.recv_total} + 32'd1) begin
                        s.recv_seq = '0;
                        s.recv_index = s.recv_index + 1;
                    end else begin
                        s.recv_seq = nxt[15:0];
                    end
                    return 1'b1;
                end
            end
            OP_POLL: begin
                if (s.count == 0)
                    return 1'b0;
                if (!s.awaiting) begin
                    len = {16'd0, s.lengths[s.head % QUEUE_DEPTH_DEF]};
                    pkt.kind = KIND_DATA;
                    pkt.index = s.send_index;
                    pkt.seq = s.send_seq;
                    if (s.send_seq == 0) begin
                        s.send_total = 16'((len + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF);
                        pkt.total = s.send_total;
                        pkt.size = COUNT_PKT_SIZE;
                    end else begin
                        off = 64'(CHUNK_BYTES_DEF) * 64'({16'd0, s.send_seq} - 32'd1);
                        pkt.offset = off[15:0];
                        if (off < 64'(len)) begin
                            rem = len - off[31:0];
                            pkt.size = (rem > CHUNK_BYTES_DEF) ? SIZE_W'(CHUNK_BYTES_DEF)
                                                               : SIZE_W'(rem);
                        end
                    end
                    s.awaiting = 1'b1;
                    if (s.timeout_en)
                        s.sent_at = ev.now_tick;
                    return 1'b1;
                end
                elapsed = ev.now_tick - s.sent_at;
                if (s.timeout_en && elapsed >= s.retry)
                    s.awaiting = 1'b0;
            end
            OP_ENQ: begin
                if (s.count < QUEUE_DEPTH_DEF) begin
                    s.lengths[(s.head + s.count) % QUEUE_DEPTH_DEF] = ev.message_length;
                    s.count = s.count + 1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic arq_event_t random_event();
        arq_event_t ev;
        ev.op = t_op'($urandom_range(3));
        ev.is_ack = $urandom_range(1);
        ev.pkt_index = $urandom;
        ev.pkt_seq = $urandom_range(65535);
        ev.pkt_count_word = $urandom_range(65535);
        ev.message_length = $urandom_range(65535);
        ev.now_tick = $urandom;
        return ev;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        if ($urandom_range(9) == 0)
            return '0;
        return LEN_W'($urandom_range(1, 1500));
    endfunction

    // Next step of a send: poll, acknowledge the pending packet or a stray one, or poll to test the retry.
    function automatic arq_event_t sender_move(input arq_state_t p);
        arq_event_t ev;
        int roll;
        ev = random_event();
        roll = $urandom_range(99);
        if (!p.awaiting) begin
            tick_now = tick_now + $urandom_range(1, 300);
            ev.op = OP_POLL;
            ev.now_tick = tick_now;
        end else if (roll < 65) begin
            ev.op = OP_RECV;
            ev.is_ack = 1'b1;
            ev.pkt_index = p.send_index;
            ev.pkt_seq = p.send_seq;
        end else if (roll < 75) begin
            ev.op = OP_RECV;
            ev.is_ack = 1'b1;
            ev.pkt_index = p.send_index + $urandom_range(1);
            ev.pkt_seq = p.send_seq + 1;
        end else if (roll < 88) begin
            ev.op = OP_POLL;
            ev.now_tick = p.sent_at + p.retry + $urandom_range(1);
        end else begin
            ev.op = OP_POLL;
            ev.now_tick = p.sent_at + $urandom_range(999);
        end
        return ev;
    endfunction

    task automatic queue_item(arq_event_t ev);
        arq_packet_t scratch;
        void'(arq_advance(plan_state, ev, scratch));
        stim_events.push_back(ev);
        issued_count++;
    endtask

    task automatic push_event(logic [OP_W-1:0] op, logic ack, logic [IDX_W-1:0] idx,
                              logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] cnt,
                              logic [LEN_W-1:0] len, logic [TICK_W-1:0] tick);
        arq_event_t ev;
        ev.op = t_op'(op);
        ev.is_ack = ack;
        ev.pkt_index = idx;
        ev.pkt_seq = seq;
        ev.pkt_count_word = cnt;
        ev.message_length = len;
        ev.now_tick = tick;
        queue_item(ev);
    endtask

    task automatic flag_error(string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] seen, logic [31:0] want);
        if (seen !== want)
            flag_error($sformatf("%s got 0x%0h want 0x%0h", name, seen, want));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (accepted_count != issued_count || due_packets.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] retry, logic en, int idle, int stall, int enq_bias,
                             bit fill);
        arq_event_t ev;
        int roll;
        write_reg(CFG_RETRY_TIMEOUT, retry);
        write_reg(CFG_TIMEOUT_EN, ($urandom & ~32'd1) | {31'd0, en});
        send_idle_pct = idle;
        stall_pct = stall;
        plan_state = link_state;
        if (fill) begin
            while (plan_state.count < QUEUE_DEPTH_DEF)
                push_event(OP_ENQ, $urandom_range(1), $urandom, 0, 0, pick_length(), $urandom);
            push_event(OP_ENQ, $urandom_range(1), $urandom, 0, 0, pick_length(), $urandom);
        end
        for (int i = 0; i < PHASE_EVENTS; i++) begin
            roll = $urandom_range(99);
            ev = random_event();
            if (roll < 20) begin
                if (ev.op == OP_ENQ && $urandom_range(99) < 97)
                    ev.message_length = pick_length();
            end else if (roll < 45) begin
                ev.op = OP_RECV;
                ev.is_ack = 1'b0;
                ev.pkt_index = plan_state.recv_index;
                ev.pkt_seq = plan_state.recv_seq;
                ev.pkt_count_word = ($urandom_range(99) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(4);
                if ($urandom_range(9) == 0)
                    ev.pkt_seq = plan_state.recv_seq - 1;
            end else if (plan_state.count == 0 || $urandom_range(99) < enq_bias) begin
                ev.op = OP_ENQ;
                ev.message_length = pick_length();
            end else begin
                ev = sender_move(plan_state);
            end
            queue_item(ev);
        end
        wait_idle();
    endtask

    // Drain the send queue, then push the longest message through its first fragments.
    task automatic run_long_message();
        int guard;
        guard = 0;
        plan_state = link_state;
        while (plan_state.count != 0 && guard < 1000) begin
            queue_item(sender_move(plan_state));
            guard++;
        end
        push_event(OP_ENQ, 1'b0, 0, 0, 0, '1, 0);
        while (plan_state.count != 0 && plan_state.send_seq < 3 && guard < 1000) begin
            queue_item(sender_move(plan_state));
            guard++;
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin : drive_events
        arq_event_t nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (stim_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nx = stim_events.pop_front();
                i_in_valid <= 1'b1;
                i_operation <= nx.op;
                i_is_ack <= nx.is_ack;
                i_pkt_index <= nx.pkt_index;
                i_pkt_seq <= nx.pkt_seq;
                i_pkt_count_word <= nx.pkt_count_word;
                i_message_length <= nx.message_length;
                i_now_tick <= nx.now_tick;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : watch_link
        arq_event_t cur;
        arq_packet_t seen;
        arq_packet_t want;
        arq_packet_t pkt;
        if (!i_rst_n) begin
            link_state = '0;
            link_state.retry = RETRY_RESET;
            link_state.timeout_en = TIMEOUT_EN_RESET;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen.kind = o_out_kind;
                seen.index = o_out_index;
                seen.seq = o_out_seq;
                seen.total = o_fragment_total;
                seen.offset = o_payload_offset;
                seen.size = o_payload_size;
                if (due_packets.size() == 0) begin
                    flag_error($sformatf("unexpected packet kind %0d index 0x%0h seq %0d",
                                         seen.kind, seen.index, seen.seq));
                end else begin
                    want = due_packets.pop_front();
                    check_field("out_kind", seen.kind, want.kind);
                    check_field("out_index", seen.index, want.index);
                    check_field("out_seq", seen.seq, want.seq);
                    check_field("fragment_total", seen.total, want.total);
                    check_field("payload_offset", seen.offset, want.offset);
                    check_field("payload_size", seen.size, want.size);
                end
            end
            if (i_in_valid && o_in_ready) begin
                cur.op = t_op'(i_operation);
                cur.is_ack = i_is_ack;
                cur.pkt_index = i_pkt_index;
                cur.pkt_seq = i_pkt_seq;
                cur.pkt_count_word = i_pkt_count_word;
                cur.message_length = i_message_length;
                cur.now_tick = i_now_tick;
                if (arq_advance(link_state, cur, pkt))
                    due_packets.push_back(pkt);
                accepted_count++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RETRY_TIMEOUT: link_state.retry = i_cfg_data;
                    CFG_TIMEOUT_EN:    link_state.timeout_en = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        plan_state = link_state;

        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 0);
        push_event(OP_RECV, 1'b1, 0, 0, 0, 0, 0);
        push_event(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1);
        push_event(OP_RECV, 1'b0, 1, 0, 3, 0, 0);
        push_event(OP_RECV, 1'b0, 0, 0, 2, 0, 0);
        push_event(OP_RECV, 1'b0, 0, 1, 0, 0, 0);
        push_event(OP_RECV, 1'b0, 0, 1, 0, 0, 0);
        push_event(OP_RECV, 1'b0, 0, 2, 0, 0, 0);
        push_event(OP_RECV, 1'b0, 1, 0, 0, 0, 0);
        push_event(OP_ENQ, 1'b0, 0, 0, 0, 0, 0);
        push_event(OP_ENQ, 1'b0, 0, 0, 0, 497, 0);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 100);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 200);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 600);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 601);
        push_event(OP_RECV, 1'b1, 0, 1, 0, 0, 0);
        push_event(OP_RECV, 1'b1, 0, 0, 0, 0, 0);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 32'h0000_01F3);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 32'h0000_01F4);
        push_event(OP_RECV, 1'b1, 1, 0, 0, 0, 0);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 1000);
        push_event(OP_RECV, 1'b1, 1, 1, 0, 0, 0);
        push_event(OP_POLL, 1'b0, 0, 0, 0, 0, 1100);
        push_event(OP_RECV, 1'b1, 1, 2, 0, 0, 0);
        push_event(OP_RECV, 1'b0, '1, '1, '1, '1, '1);
        wait_idle();

        run_phase(32'd500, 1'b1, 0, 0, 10, 1'b0);
        run_phase(32'd0, 1'b1, 54, 0, 10, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b0, 0, 54, 10, 1'b0);
        run_phase(32'd37, 1'b1, 33, 33, 60, 1'b1);
        run_phase(32'd200, 1'b0, 0, 0, 10, 1'b0);
        run_phase($urandom_range(20, 400), 1'b1, 33, 33, 10, 1'b0);
        run_long_message();

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
